// ===== rtl/gla_pkg.sv =====
// ----------------------------------------------------------------------------
// gla_pkg : shared types and constants for the graph layer assignment block
// Widths, edge word layout, state encoding and node classification helpers.
// ----------------------------------------------------------------------------
package gla_pkg;

	localparam int MAX_NODES   = 64;
	localparam int MAX_EDGES   = 256;
	localparam int NODE_SLOTS  = 64;
	localparam int NODE_LIMIT  = (MAX_NODES < NODE_SLOTS) ? MAX_NODES : NODE_SLOTS;
	localparam int NODE_W      = 6;
	localparam int LAYER_W     = 10;
	localparam int DEEP_W      = 9;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int EDGE_AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EDGE_CW     = $clog2(MAX_EDGES + 1);
	localparam int EDGE_WORD_W = 2 * NODE_W + 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	localparam logic [LAYER_W-1:0] LAYER_NONE = {LAYER_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_INPUTS       = 2'd0,
		REG_NUM_OUTPUTS      = 2'd1,
		REG_INCLUDE_DISABLED = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_PASS_RD,
		ST_PASS_EDGE,
		ST_PASS_SRC,
		ST_PASS_DST,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	typedef struct packed {
		logic [CFG_W-1:0] num_inputs;
		logic [CFG_W-1:0] num_outputs;
		logic             include_disabled;
	} cfg_t;

	typedef struct packed {
		logic [NODE_W-1:0] src_node;
		logic [NODE_W-1:0] dst_node;
		logic              edge_enabled;
		logic              last_edge;
	} edge_beat_t;

	typedef struct packed {
		logic [NODE_W-1:0]         node_index;
		logic signed [LAYER_W-1:0] node_layer;
		logic                      last_node;
		logic                      edge_overflow;
	} node_beat_t;

	// edge word: src [13:8], dst [7:2], enabled [1], consumed [0]
	function automatic logic [NODE_W-1:0] w_src(input logic [EDGE_WORD_W-1:0] w);
		return w[EDGE_WORD_W-1 -: NODE_W];
	endfunction

	function automatic logic [NODE_W-1:0] w_dst(input logic [EDGE_WORD_W-1:0] w);
		return w[NODE_W+1 -: NODE_W];
	endfunction

	function automatic logic w_en(input logic [EDGE_WORD_W-1:0] w);
		return w[1];
	endfunction

	function automatic logic w_used(input logic [EDGE_WORD_W-1:0] w);
		return w[0];
	endfunction

	function automatic logic qualifies(input logic [EDGE_WORD_W-1:0] w, input cfg_t c);
		return (c.include_disabled | w_en(w)) &&
			(int'(w_src(w)) < NODE_LIMIT) && (int'(w_dst(w)) < NODE_LIMIT);
	endfunction

	function automatic logic is_input(input logic [NODE_W-1:0] n, input cfg_t c);
		return CFG_W'(n) < c.num_inputs;
	endfunction

	function automatic logic is_output(input logic [NODE_W-1:0] n, input cfg_t c);
		logic [CFG_W:0] top_n;
		top_n = {1'b0, c.num_inputs} + {1'b0, c.num_outputs};
		return (CFG_W'(n) >= c.num_inputs) && ((CFG_W+1)'(n) < top_n);
	endfunction

endpackage

// ===== rtl/graph_layer_assignment_top.sv =====
// Edge beats load at one per cycle while the block is idle. After the last-edge beat the
// block initialises every layer slot, scans the stored edges for the largest node, then
// runs passes that skip an edge on its flags or an output target, stop at an unreached
// source or consume it, then reads the nodes out, waiting while m_axis_tready is low.
// One graph at a time, set by the single edge RAM and layer RAM ports.
// Reset (arst_n low): control state, edge count, overflow cleared, config to 1/1/0.
// ----------------------------------------------------------------------------
// graph_layer_assignment_top : longest-path layering of a streamed edge list
// Stores edges, relaxes node layers pass by pass and streams one layer per node.
// ----------------------------------------------------------------------------
module graph_layer_assignment_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// edge beats
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [gla_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // src_node, dst_node, edge_enabled
	input  logic                             s_axis_tlast,  // last_edge
	// node beats
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [gla_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // node_index, node_layer
	output logic                             m_axis_tlast,  // last_node
	output logic                             m_axis_tuser,  // edge_overflow
	// register writes
	input  logic                             cfg_wen,
	input  logic [gla_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gla_pkg::CFG_W-1:0]        cfg_wdata
);
	import gla_pkg::*;

	cfg_t       cfg_q;
	edge_beat_t in_beat;
	node_beat_t beat, out_q;
	logic       out_valid_q;
	logic       out_free;
	logic       beat_load;

	// unpack the edge beat
	assign in_beat.src_node     = s_axis_tdata[NODE_W-1:0];
	assign in_beat.dst_node     = s_axis_tdata[2*NODE_W-1:NODE_W];
	assign in_beat.edge_enabled = s_axis_tdata[2*NODE_W];
	assign in_beat.last_edge    = s_axis_tlast;

	// configuration registers; unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_inputs       <= CFG_W'(1);
			cfg_q.num_outputs      <= CFG_W'(1);
			cfg_q.include_disabled <= 1'b0;
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_index))
				REG_NUM_INPUTS:       cfg_q.num_inputs       <= cfg_wdata;
				REG_NUM_OUTPUTS:      cfg_q.num_outputs      <= cfg_wdata;
				REG_INCLUDE_DISABLED: cfg_q.include_disabled <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	gla_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_beat   (in_beat),
		.out_free  (out_free),
		.beat_load (beat_load),
		.beat      (beat)
	);

	// output register: takes a new beat when empty or being drained this cycle
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (beat_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_load) begin
			out_q <= beat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.node_layer, out_q.node_index};
	assign m_axis_tlast  = out_q.last_node;
	assign m_axis_tuser  = out_q.edge_overflow;

endmodule

// ===== rtl/gla_ram.sv =====
// ----------------------------------------------------------------------------
// gla_ram : generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/gla_seq.sv =====
// ----------------------------------------------------------------------------
// gla_seq : edge store, layer store and the relaxation sequencer
// Loads edges, scans for the largest node, relaxes edges pass by pass through
// one compare/increment path, then reads layers back node by node.
// ----------------------------------------------------------------------------
module gla_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  gla_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  gla_pkg::edge_beat_t in_beat,
	input  logic                out_free,
	output logic                beat_load,
	output gla_pkg::node_beat_t beat
);
	import gla_pkg::*;

	state_t                    state_q, state_d;
	logic [EDGE_CW-1:0]        count_q, count_d;
	logic [EDGE_CW-1:0]        eidx_q, eidx_d;
	logic [NODE_W-1:0]         nidx_q, nidx_d;
	logic [NODE_W-1:0]         largest_q, largest_d;
	logic [DEEP_W-1:0]         deep_q, deep_d;
	logic                      changed_q, changed_d;
	logic                      ovf_q, ovf_d;
	logic [EDGE_WORD_W-1:0]    edge_q, edge_d;
	logic signed [LAYER_W-1:0] cand_q, cand_d;

	logic                      e_we;
	logic [EDGE_AW-1:0]        e_waddr, e_raddr;
	logic [EDGE_WORD_W-1:0]    e_wdata, e_rdata;
	logic                      l_we;
	logic [NODE_W-1:0]         l_waddr, l_raddr;
	logic [LAYER_W-1:0]        l_wdata, l_rdata;

	logic                      adv;
	logic                      last_here;
	logic [CFG_W:0]            io_sum, cnt_raw;
	logic [NODE_W:0]           largest_p1, node_cnt;
	logic [NODE_W-1:0]         lg;

	gla_ram #(.WIDTH(EDGE_WORD_W), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	gla_ram #(.WIDTH(LAYER_W), .DEPTH(NODE_SLOTS)) u_layer_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	// nodes emitted: max(largest + 1, inputs + outputs), capped at the node limit
	assign io_sum     = {1'b0, cfg.num_inputs} + {1'b0, cfg.num_outputs};
	assign largest_p1 = {1'b0, largest_q} + (NODE_W+1)'(1);
	assign cnt_raw    = (io_sum > (CFG_W+1)'(largest_p1)) ? io_sum : (CFG_W+1)'(largest_p1);
	assign node_cnt   = (cnt_raw > (CFG_W+1)'(NODE_LIMIT)) ? (NODE_W+1)'(NODE_LIMIT) :
		cnt_raw[NODE_W:0];
	assign last_here  = ({1'b0, nidx_q} + (NODE_W+1)'(1)) == node_cnt;

	always_comb begin
		beat.node_index    = nidx_q;
		beat.last_node     = last_here;
		beat.edge_overflow = ovf_q;
		if (is_input(nidx_q, cfg)) begin
			beat.node_layer = '0;
		end else if (is_output(nidx_q, cfg)) begin
			beat.node_layer = LAYER_W'({1'b0, deep_q}) + LAYER_W'(1);
		end else begin
			beat.node_layer = l_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			eidx_q    <= '0;
			nidx_q    <= '0;
			largest_q <= '0;
			deep_q    <= '0;
			changed_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			eidx_q    <= eidx_d;
			nidx_q    <= nidx_d;
			largest_q <= largest_d;
			deep_q    <= deep_d;
			changed_q <= changed_d;
			ovf_q     <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		edge_q <= edge_d;
		cand_q <= cand_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		eidx_d    = eidx_q;
		nidx_d    = nidx_q;
		largest_d = largest_q;
		deep_d    = deep_q;
		changed_d = changed_q;
		ovf_d     = ovf_q;
		edge_d    = edge_q;
		cand_d    = cand_q;
		in_ready  = 1'b0;
		beat_load = 1'b0;
		adv       = 1'b0;
		lg        = largest_q;
		e_we      = 1'b0;
		e_waddr   = count_q[EDGE_AW-1:0];
		e_wdata   = {in_beat.src_node, in_beat.dst_node, in_beat.edge_enabled, 1'b0};
		e_raddr   = eidx_q[EDGE_AW-1:0];
		l_we      = 1'b0;
		l_waddr   = nidx_q;
		l_wdata   = is_input(nidx_q, cfg) ? '0 : LAYER_NONE;
		l_raddr   = nidx_q;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (count_q < EDGE_CW'(MAX_EDGES)) begin
						e_we    = 1'b1;
						count_d = count_q + EDGE_CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (in_beat.last_edge) begin
						state_d   = ST_INIT;
						nidx_d    = '0;
						largest_d = '0;
						deep_d    = '0;
					end
				end
			end
			ST_INIT: begin
				// one layer entry per cycle: inputs 0, everything else unreached
				l_we   = 1'b1;
				nidx_d = nidx_q + NODE_W'(1);
				if (nidx_q == NODE_W'(NODE_SLOTS - 1)) begin
					nidx_d = '0;
					eidx_d = '0;
					state_d = (count_q == '0) ? ST_OUT_RD : ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (qualifies(e_rdata, cfg)) begin
					if (w_src(e_rdata) > lg) begin
						lg = w_src(e_rdata);
					end
					if (w_dst(e_rdata) > lg) begin
						lg = w_dst(e_rdata);
					end
					largest_d = lg;
				end
				if (eidx_q + EDGE_CW'(1) == count_q) begin
					eidx_d    = '0;
					changed_d = 1'b0;
					state_d   = ST_PASS_RD;
				end else begin
					eidx_d  = eidx_q + EDGE_CW'(1);
					state_d = ST_SCAN_RD;
				end
			end
			ST_PASS_RD: begin
				state_d = ST_PASS_EDGE;
			end
			ST_PASS_EDGE: begin
				edge_d  = e_rdata;
				l_raddr = w_src(e_rdata);
				if (!w_used(e_rdata) && qualifies(e_rdata, cfg) &&
					!is_output(w_dst(e_rdata), cfg)) begin
					state_d = ST_PASS_SRC;
				end else begin
					adv = 1'b1;
				end
			end
			ST_PASS_SRC: begin
				l_raddr = w_dst(edge_q);
				if (l_rdata == LAYER_NONE) begin
					adv = 1'b1;
				end else begin
					cand_d  = $signed(l_rdata) + LAYER_W'(1);
					state_d = ST_PASS_DST;
				end
			end
			ST_PASS_DST: begin
				// edge consumed whether or not it raises its target
				e_we    = 1'b1;
				e_waddr = eidx_q[EDGE_AW-1:0];
				e_wdata = {edge_q[EDGE_WORD_W-1:1], 1'b1};
				if (cand_q > $signed(l_rdata)) begin
					l_we      = 1'b1;
					l_waddr   = w_dst(edge_q);
					l_wdata   = cand_q;
					changed_d = 1'b1;
					if (cand_q[DEEP_W-1:0] > deep_q) begin
						deep_d = cand_q[DEEP_W-1:0];
					end
				end
				adv = 1'b1;
			end
			ST_OUT_RD: begin
				state_d = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				if (out_free) begin
					beat_load = 1'b1;
					if (last_here) begin
						state_d = ST_IDLE;
						count_d = '0;
						ovf_d   = 1'b0;
					end else begin
						nidx_d  = nidx_q + NODE_W'(1);
						state_d = ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// step to the next stored edge; end of pass restarts or finishes
		if (adv) begin
			if (eidx_q + EDGE_CW'(1) == count_q) begin
				eidx_d = '0;
				if (changed_d) begin
					changed_d = 1'b0;
					state_d   = ST_PASS_RD;
				end else begin
					nidx_d  = '0;
					state_d = ST_OUT_RD;
				end
			end else begin
				eidx_d  = eidx_q + EDGE_CW'(1);
				state_d = ST_PASS_RD;
			end
		end
	end

endmodule

// ===== rtl/gla_chk.sv =====
// ----------------------------------------------------------------------------
// gla_chk : port-level checks for the graph layer assignment block
// Watches the stream ports for run sequencing slips; bound to the top level.
// ----------------------------------------------------------------------------
module gla_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            s_axis_tlast,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [gla_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast,
	input logic                            m_axis_tuser
);

	// the last edge starts a run: no further edge is taken next cycle
	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
		else $error("edge taken straight after last edge");

	// an ordinary edge keeps the block in loading
	a_load_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> s_axis_tready)
		else $error("input stalled after a non-last edge");

	// while a run is still being emitted no edge is taken
	a_busy_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
		else $error("input ready in the middle of a run");

	// a stalled node beat holds its payload
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			($stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)))
		else $error("node beat changed while stalled");

endmodule

bind graph_layer_assignment_top gla_chk u_gla_chk (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : testbench for graph_layer_assignment_top
// Streams edge lists, predicts the per-node layers of each graph in a local
// model and checks every node beat, under varying idle patterns and settings.
// ----------------------------------------------------------------------------
module tb;
	import gla_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int RST_CYCLES  = 8;
	localparam int SETTLE      = 16;       // margin once the last node beat is in
	localparam int HOLD_CYCLES = 400;      // long receiver hold-off
	localparam int TIMEOUT_NS  = 20_000_000;
	localparam int MAX_REPORTS = 10;
	localparam int REG_UNUSED  = 3;        // index with no register behind it

	// directed table: edge beats and register writes
	typedef enum bit {ROW_EDGE, ROW_REG} row_kind_t;
	typedef struct {
		row_kind_t kind;
		int        a;        // src node, or register index
		int        b;        // dst node, or register value
		bit        en;
		bit        last;
		int        n_typed;  // node beats typed in below, 0 = use the predictor
		int        lay [4];
	} dir_row_t;

	typedef struct {
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
		logic              en;
	} graph_edge_t;

	localparam int DIR_ROWS = 23;
	dir_row_t dir_tab [DIR_ROWS] = '{
		// reset settings: 1 input, 1 output, disabled edges left out
		'{ROW_EDGE, 0, 1, 1'b1, 1'b1, 2, '{0, 1, 0, 0}},
		'{ROW_EDGE, 0, 2, 1'b1, 1'b0, 0, '{0, 0, 0, 0}},
		'{ROW_EDGE, 2, 3, 1'b1, 1'b1, 4, '{0, 3, 1, 2}},
		'{ROW_EDGE, 5, 6, 1'b0, 1'b1, 2, '{0, 1, 0, 0}},   // only edge disabled
		'{ROW_EDGE, 0, 0, 1'b1, 1'b1, 2, '{0, 2, 0, 0}},   // self loop on an input
		'{ROW_EDGE, 2, 3, 1'b1, 1'b0, 0, '{0, 0, 0, 0}},   // needs a second pass
		'{ROW_EDGE, 0, 2, 1'b1, 1'b1, 0, '{0, 0, 0, 0}},
		'{ROW_EDGE, 0, 63, 1'b1, 1'b0, 0, '{0, 0, 0, 0}},  // top node, raises an input
		'{ROW_EDGE, 63, 0, 1'b1, 1'b1, 0, '{0, 0, 0, 0}},
		'{ROW_EDGE, 63, 0, 1'b0, 1'b1, 2, '{0, 1, 0, 0}},
		// disabled edges in, no inputs, no outputs, stray index ignored
		'{ROW_REG, int'(REG_INCLUDE_DISABLED), 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0}},
		'{ROW_REG, int'(REG_NUM_INPUTS), 0, 1'b0, 1'b0, 0, '{0, 0, 0, 0}},
		'{ROW_REG, int'(REG_NUM_OUTPUTS), 0, 1'b0, 1'b0, 0, '{0, 0, 0, 0}},
		'{ROW_REG, REG_UNUSED, 127, 1'b0, 1'b0, 0, '{0, 0, 0, 0}},
		'{ROW_EDGE, 1, 2, 1'b0, 1'b1, 3, '{-1, -1, -1, 0}},
		// two inputs, one output; edge into the output is skipped
		'{ROW_REG, int'(REG_NUM_INPUTS), 2, 1'b0, 1'b0, 0, '{0, 0, 0, 0}},
		'{ROW_REG, int'(REG_NUM_OUTPUTS), 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0}},
		'{ROW_EDGE, 0, 3, 1'b0, 1'b0, 0, '{0, 0, 0, 0}},
		'{ROW_EDGE, 1, 3, 1'b1, 1'b0, 0, '{0, 0, 0, 0}},
		'{ROW_EDGE, 3, 2, 1'b1, 1'b1, 4, '{0, 0, 2, 1}},
		// register maxima: count saturates, every node an input
		'{ROW_REG, int'(REG_NUM_INPUTS), 127, 1'b0, 1'b0, 0, '{0, 0, 0, 0}},
		'{ROW_REG, int'(REG_NUM_OUTPUTS), 127, 1'b0, 1'b0, 0, '{0, 0, 0, 0}},
		'{ROW_EDGE, 5, 9, 1'b1, 1'b1, 0, '{0, 0, 0, 0}}
	};

	// settings per phase: inputs, outputs, include disabled
	int cfg_set [9][3] = '{
		'{2, 2, 0}, '{1, 63, 1}, '{64, 0, 0},
		'{3, 1, 1}, '{0, 64, 0}, '{127, 127, 1},
		'{4, 3, 0}, '{8, 8, 1}, '{1, 1, 0}
	};

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tlast  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   m_axis_tuser;
	logic                   cfg_wen       = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_W-1:0]       cfg_wdata     = '0;

	// stimulus shaping
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_kick    = 1'b0;
	bit rx_hold      = 1'b0;

	// predictor copy of the settings and of the graph being collected
	int          cfg_ni   = 1;
	int          cfg_no   = 1;
	bit          cfg_incl = 1'b0;
	graph_edge_t graph_edges [$];
	bit          graph_overflow = 1'b0;

	node_beat_t exp_nodes [$];    // node beats still to come, oldest first
	node_beat_t typed_nodes [$];  // hand-written beats for the next graph
	int         mismatches = 0;

	graph_layer_assignment_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #(CLK_HALF) clk = ~clk;

	// ---- layering predictor ------------------------------------------------

	function automatic bit edge_counts(input graph_edge_t e);
		return (cfg_incl || e.en) && (int'(e.src) < NODE_LIMIT) && (int'(e.dst) < NODE_LIMIT);
	endfunction

	function automatic bit node_is_output(input int n);
		return (n >= cfg_ni) && (n < cfg_ni + cfg_no);
	endfunction

	// Longest-path relaxation over the collected edges; one beat per node.
	function automatic void layer_graph(output node_beat_t res [$]);
		int         lay [NODE_SLOTS];
		bit         used [MAX_EDGES];
		int         top;
		int         cnt;
		int         deepest;
		int         cand;
		int         s;
		int         d;
		int         l;
		bit         changed;
		node_beat_t nb;

		res = {};
		top = 0;
		foreach (graph_edges[i]) begin
			if (edge_counts(graph_edges[i])) begin
				if (int'(graph_edges[i].src) > top) top = int'(graph_edges[i].src);
				if (int'(graph_edges[i].dst) > top) top = int'(graph_edges[i].dst);
			end
		end
		cnt = top + 1;
		if (cfg_ni + cfg_no > cnt) cnt = cfg_ni + cfg_no;
		if (cnt > NODE_LIMIT) cnt = NODE_LIMIT;

		for (int i = 0; i < NODE_SLOTS; i++) lay[i] = (i < cfg_ni) ? 0 : -1;
		used    = '{default: 1'b0};
		deepest = 0;

		// raises land at once, so a pass sees earlier raises of the same pass
		changed = 1'b1;
		while (changed) begin
			changed = 1'b0;
			foreach (graph_edges[i]) begin
				if (used[i] || !edge_counts(graph_edges[i])) continue;
				s = int'(graph_edges[i].src);
				d = int'(graph_edges[i].dst);
				if (lay[s] == -1 || node_is_output(d)) continue;
				cand = lay[s] + 1;
				if (cand > lay[d]) begin
					lay[d]  = cand;
					changed = 1'b1;
					if (cand > deepest) deepest = cand;
				end
				used[i] = 1'b1;
			end
		end

		for (int i = 0; i < NODE_SLOTS; i++) begin
			if (i < cfg_ni) lay[i] = 0;
			else if (node_is_output(i)) lay[i] = deepest + 1;
		end

		for (int i = 0; i < cnt; i++) begin
			l = (lay[i] > 511) ? 511 : lay[i];
			nb.node_index    = NODE_W'(i);
			nb.node_layer    = LAYER_W'(l);
			nb.last_node     = (i == cnt - 1);
			nb.edge_overflow = graph_overflow;
			res = {res, nb};
		end

		graph_edges.delete();
		graph_overflow = 1'b0;
	endfunction

	// ---- edge side ---------------------------------------------------------

	// Offers one edge beat and books it once accepted. tvalid stays high on
	// return so back-to-back beats need no toggle.
	task automatic send_edge(input int src, input int dst, input bit en, input bit last);
		node_beat_t  pred [$];
		graph_edge_t ge;

		while ($urandom_range(99) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, en, NODE_W'(dst), NODE_W'(src)};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);

		ge.src = NODE_W'(src);
		ge.dst = NODE_W'(dst);
		ge.en  = en;
		if (graph_edges.size() < MAX_EDGES) graph_edges = {graph_edges, ge};
		else graph_overflow = 1'b1;

		if (last) begin
			layer_graph(pred);
			if (typed_nodes.size() != 0) begin
				exp_nodes = {exp_nodes, typed_nodes};
				typed_nodes.delete();
			end else begin
				exp_nodes = {exp_nodes, pred};
			end
		end
	endtask

	// Random graph: mostly forward edges within the populated node range, so
	// layers chain up across passes; the rest is noise over all node numbers.
	task automatic send_graph(input int n_edges);
		int base;
		int span;
		int a;
		int b;
		int t;

		base = (cfg_ni + cfg_no > NODE_LIMIT) ? NODE_LIMIT : cfg_ni + cfg_no;
		span = base + $urandom_range(2, 8);
		if (span > NODE_LIMIT) span = NODE_LIMIT;
		for (int i = 0; i < n_edges; i++) begin
			if ($urandom_range(9) < 7) begin
				a = $urandom_range(span - 1);
				b = $urandom_range(span - 1);
				if (a > b) begin
					t = a;
					a = b;
					b = t;
				end
			end else begin
				a = $urandom_range(63);
				b = $urandom_range(63);
			end
			send_edge(a, b, $urandom_range(99) < 80, i == n_edges - 1);
		end
	endtask

	// Block idle: every node beat in, then a margin for it to settle.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (exp_nodes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input int idx, input int val);
		cfg_wen   <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_wdata <= CFG_W'(val);
		@(posedge clk);
		if (idx == int'(REG_NUM_INPUTS)) cfg_ni = val & 127;
		else if (idx == int'(REG_NUM_OUTPUTS)) cfg_no = val & 127;
		else if (idx == int'(REG_INCLUDE_DISABLED)) cfg_incl = val[0];
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input int ni, input int no, input int incl);
		write_reg(int'(REG_NUM_INPUTS), ni);
		write_reg(int'(REG_NUM_OUTPUTS), no);
		write_reg(int'(REG_INCLUDE_DISABLED), incl);
	endtask

	// ---- node side ---------------------------------------------------------

	// long hold-off, timed here so the sender keeps pushing meanwhile
	always @(hold_kick) begin
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_hold) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// compare each accepted node beat with the oldest prediction
	always @(posedge clk) begin
		node_beat_t want;
		node_beat_t got;

		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.node_index    = m_axis_tdata[NODE_W-1:0];
			got.node_layer    = m_axis_tdata[NODE_W +: LAYER_W];
			got.last_node     = m_axis_tlast;
			got.edge_overflow = m_axis_tuser;
			if (exp_nodes.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%t: unexpected node beat idx %0d layer %0d", $realtime,
						got.node_index, got.node_layer);
				mismatches++;
			end else begin
				want = exp_nodes.pop_front();
				if (got.node_index !== want.node_index || got.node_layer !== want.node_layer ||
						got.last_node !== want.last_node ||
						got.edge_overflow !== want.edge_overflow) begin
					if (mismatches < MAX_REPORTS)
						$display("%t: node beat mismatch exp idx %0d layer %0d last %0b ovf %0b,",
							$realtime, want.node_index, want.node_layer, want.last_node,
							want.edge_overflow,
							" got idx %0d layer %0d last %0b ovf %0b",
							got.node_index, got.node_layer, got.last_node,
							got.edge_overflow);
					mismatches++;
				end
			end
		end
	end

	// ---- sequence ----------------------------------------------------------

	initial begin
		node_beat_t nb;

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at light sender idling, heavy receiver idling
		snd_idle_pct  = 7;
		rcv_idle_pct <= 86;
		foreach (dir_tab[r]) begin
			if (dir_tab[r].kind == ROW_REG) begin
				wait_drained();
				write_reg(dir_tab[r].a, dir_tab[r].b);
			end else begin
				for (int i = 0; i < dir_tab[r].n_typed; i++) begin
					nb.node_index    = NODE_W'(i);
					nb.node_layer    = LAYER_W'(dir_tab[r].lay[i]);
					nb.last_node     = (i == dir_tab[r].n_typed - 1);
					nb.edge_overflow = 1'b0;
					typed_nodes      = {typed_nodes, nb};
				end
				send_edge(dir_tab[r].a, dir_tab[r].b, dir_tab[r].en, dir_tab[r].last);
			end
		end

		// random part: three idle patterns, four settings each, two graphs per
		// setting sent back to back
		for (int rg = 0; rg < 3; rg++) begin
			case (rg)
				0: begin
					snd_idle_pct  = 7;
					rcv_idle_pct <= 86;
				end
				1: begin
					snd_idle_pct  = 86;
					rcv_idle_pct <= 7;
				end
				default: begin
					snd_idle_pct  = 0;
					rcv_idle_pct <= 0;
				end
			endcase
			for (int st = 0; st < 4; st++) begin
				wait_drained();
				if (st < 3)
					apply_setting(cfg_set[rg*3+st][0], cfg_set[rg*3+st][1], cfg_set[rg*3+st][2]);
				else
					apply_setting($urandom_range(0, 20), $urandom_range(0, 12), $urandom_range(1));
				// output stalls long enough to back up into the edge side
				if (rg == 2 && st == 0) hold_kick <= ~hold_kick;
				for (int g = 0; g < 2; g++) send_graph($urandom_range(1, 9));
			end
		end

		// store overflow: edges beyond MAX_EDGES dropped, last flag on a dropped edge
		wait_drained();
		apply_setting(2, 2, 1);
		send_graph(MAX_EDGES + 2);

		wait_drained();
		repeat (64) @(posedge clk);
		if (mismatches == 0 && exp_nodes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule
